@@ hdl/rish_pkg.sv @@
`default_nettype none
package rish_pkg;

	localparam int MAX_LEN_DEF = 256;
	localparam logic [31:0] HASH_SEED = 32'd5381;
	localparam int HASH_SHIFT = 5;

	typedef enum logic [6:0] {
		ST_IDLE     = 7'b0000001,
		ST_CMP_RD   = 7'b0000010,
		ST_CMP_EV   = 7'b0000100,
		ST_HASH_SET = 7'b0001000,
		ST_HASH_RD  = 7'b0010000,
		ST_HASH_EV  = 7'b0100000,
		ST_DONE     = 7'b1000000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic cmp_eval;
		logic hash_sel;
		logic hash_init;
		logic hash_eval;
		logic clear;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cmp_run;
		logic hash_more;
	} status_t;

endpackage
`default_nettype wire

@@ hdl/rish_ram.sv @@
`default_nettype none
module rish_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire  [$clog2(DEPTH)-1:0] raddr_a,
	input  wire  [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule
`default_nettype wire

@@ hdl/rish_ctrl.sv @@
`default_nettype none
module rish_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire                last_byte,
	input  wire                empty_string,
	input  wire rish_pkg::status_t status,
	output rish_pkg::cmd_t     cmd,
	output logic               busy,
	output logic               done
);

	rish_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rish_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			rish_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (empty_string || last_byte) begin
						state_d = rish_pkg::ST_CMP_RD;
					end
				end
			end
			rish_pkg::ST_CMP_RD: begin
				// read addresses are the candidates plus the match run, wrapped at the length
				if (status.cmp_run) begin
					state_d = rish_pkg::ST_CMP_EV;
				end else begin
					state_d = rish_pkg::ST_HASH_SET;
				end
			end
			rish_pkg::ST_CMP_EV: begin
				cmd.cmp_eval = 1'b1;
				state_d = rish_pkg::ST_CMP_RD;
			end
			rish_pkg::ST_HASH_SET: begin
				cmd.hash_init = 1'b1;
				state_d = rish_pkg::ST_HASH_RD;
			end
			rish_pkg::ST_HASH_RD: begin
				cmd.hash_sel = 1'b1;
				if (status.hash_more) begin
					state_d = rish_pkg::ST_HASH_EV;
				end else begin
					state_d = rish_pkg::ST_DONE;
				end
			end
			rish_pkg::ST_HASH_EV: begin
				cmd.hash_eval = 1'b1;
				state_d = rish_pkg::ST_HASH_RD;
			end
			rish_pkg::ST_DONE: begin
				cmd.clear = 1'b1;
				state_d = rish_pkg::ST_IDLE;
			end
			default: begin
				state_d = rish_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != rish_pkg::ST_IDLE);
	assign done = (state_q == rish_pkg::ST_DONE);

endmodule
`default_nettype wire

@@ hdl/rish_dp.sv @@
`default_nettype none
module rish_dp #(
	parameter int MAX_LEN = rish_pkg::MAX_LEN_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire rish_pkg::cmd_t cmd,
	input  wire                empty_string,
	input  wire  [7:0]         data_byte,
	output rish_pkg::status_t  status,
	output logic [31:0]        hash_value,
	output logic [7:0]         least_start,
	output logic [8:0]         string_length_out,
	output logic               overflow_flag
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int CW = LW + 1;

	logic [LW-1:0] len_q;
	logic          drop_q;
	logic [CW-1:0] cand_a_q, cand_b_q, run_q;
	logic [CW-1:0] pos_q, start_q;
	logic [LW-1:0] cnt_q;
	logic [31:0]   hash_q;

	logic [CW-1:0] n_ext, sum_a, sum_b, idx_a, idx_b;
	logic [CW-1:0] a_inc, b_inc, lo_cand, pos_inc;
	logic [AW-1:0] raddr_a, raddr_b;
	logic [7:0]    rd_a, rd_b;
	logic          room, we;

	assign n_ext = CW'(len_q);
	assign room  = (len_q < LW'(MAX_LEN));
	assign we    = cmd.load && !empty_string && room;

	// wrap-around indexing: both sums stay below twice the length
	assign sum_a = cand_a_q + run_q;
	assign sum_b = cand_b_q + run_q;
	assign idx_a = (sum_a >= n_ext) ? (sum_a - n_ext) : sum_a;
	assign idx_b = (sum_b >= n_ext) ? (sum_b - n_ext) : sum_b;

	assign raddr_a = cmd.hash_sel ? pos_q[AW-1:0] : idx_a[AW-1:0];
	assign raddr_b = idx_b[AW-1:0];

	rish_ram #(
		.WIDTH(8),
		.DEPTH(MAX_LEN)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (len_q[AW-1:0]),
		.wdata   (data_byte),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	assign a_inc   = cand_a_q + run_q + CW'(1);
	assign b_inc   = cand_b_q + run_q + CW'(1);
	assign lo_cand = (cand_a_q < cand_b_q) ? cand_a_q : cand_b_q;
	assign pos_inc = pos_q + CW'(1);

	assign status.cmp_run   = (cand_a_q < n_ext) && (cand_b_q < n_ext) && (run_q < n_ext);
	assign status.hash_more = (cnt_q < len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= '0;
			drop_q   <= 1'b0;
			cand_a_q <= '0;
			cand_b_q <= CW'(1);
			run_q    <= '0;
			cnt_q    <= '0;
		end else begin
			if (cmd.load && !empty_string) begin
				if (room) begin
					len_q <= len_q + LW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.cmp_eval) begin
				if (rd_a == rd_b) begin
					run_q <= run_q + CW'(1);
				end else if (rd_a > rd_b) begin
					cand_a_q <= (a_inc <= cand_b_q) ? (cand_b_q + CW'(1)) : a_inc;
					run_q    <= '0;
				end else begin
					cand_b_q <= (b_inc <= cand_a_q) ? (cand_a_q + CW'(1)) : b_inc;
					run_q    <= '0;
				end
			end
			if (cmd.hash_init) begin
				cnt_q <= '0;
			end else if (cmd.hash_eval) begin
				cnt_q <= cnt_q + LW'(1);
			end
			if (cmd.clear) begin
				len_q    <= '0;
				drop_q   <= 1'b0;
				cand_a_q <= '0;
				cand_b_q <= CW'(1);
				run_q    <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.hash_init) begin
			start_q <= (len_q == '0) ? '0 : lo_cand;
			pos_q   <= (len_q == '0) ? '0 : lo_cand;
			hash_q  <= rish_pkg::HASH_SEED;
		end else if (cmd.hash_eval) begin
			hash_q <= ((hash_q << rish_pkg::HASH_SHIFT) + hash_q) ^ 32'(rd_a);
			pos_q  <= (pos_inc >= n_ext) ? '0 : pos_inc;
		end
	end

	assign hash_value        = hash_q;
	assign least_start       = 8'(start_q);
	assign string_length_out = 9'(len_q);
	assign overflow_flag     = drop_q;

endmodule
`default_nettype wire

@@ hdl/rotation_invariant_string_hash.sv @@
`default_nettype none
// rotation-invariant string hash
// request channel: drive start with data_byte, last_byte and empty_string; a
// request is taken at a rising edge with start high and busy low. one byte per
// request; busy stays low while loading, so requests can follow back to back.
// last_byte or empty_string ends the string (empty_string adds no byte; it wins
// when both are set). after the ending request busy stays high while the block
// finds the start of the least rotation and hashes from there. each comparison
// step is a store read then a compare, and there are at most about 2n of them;
// the hash does a store read then an update per byte (registered read port).
// the result (hash_value, least_start, string_length_out, overflow_flag) is
// shown for exactly one cycle with done high; the receiver cannot stall it.
// bytes past MAX_LEN are dropped and set overflow_flag for that string.
// reset clears the length, flags and controller; the byte store needs no
// clearing since only bytes of the current string are read.
module rotation_invariant_string_hash #(
	parameter int MAX_LEN = rish_pkg::MAX_LEN_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [7:0]  data_byte,
	input  wire         last_byte,
	input  wire         empty_string,
	output logic        done,
	output logic [31:0] hash_value,
	output logic [7:0]  least_start,
	output logic [8:0]  string_length_out,
	output logic        overflow_flag
);

	rish_pkg::cmd_t    cmd;
	rish_pkg::status_t status;

	rish_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.last_byte    (last_byte),
		.empty_string (empty_string),
		.status       (status),
		.cmd          (cmd),
		.busy         (busy),
		.done         (done)
	);

	rish_dp #(
		.MAX_LEN(MAX_LEN)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.empty_string      (empty_string),
		.data_byte         (data_byte),
		.status            (status),
		.hash_value        (hash_value),
		.least_start       (least_start),
		.string_length_out (string_length_out),
		.overflow_flag     (overflow_flag)
	);

endmodule
`default_nettype wire

@@ sim/rotation_invariant_string_hash_tb.sv @@
`timescale 1ns / 100ps
module rotation_invariant_string_hash_tb;

	localparam int CAP = rish_pkg::MAX_LEN_DEF;
	// worst case for a full store: about 2n compare steps plus the hash
	localparam int SETTLE_CYCLES = 1600;

	typedef struct packed {
		logic [31:0] hash;
		logic [7:0]  first;
		logic [8:0]  len;
		logic        ovf;
	} digest_t;

	typedef enum {END_ON_LAST, END_ON_MARK} string_end_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  data_byte;
	logic        last_byte;
	logic        empty_string;
	logic        done;
	logic [31:0] hash_value;
	logic [7:0]  least_start;
	logic [8:0]  string_length_out;
	logic        overflow_flag;

	logic [7:0] str_mem [CAP];
	int         str_len;
	logic       str_dropped;
	digest_t    pending_digests[$];
	int         gap_pct;
	int         miss_count;

	rotation_invariant_string_hash #(
		.MAX_LEN(CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.empty_string(empty_string),
		.done(done),
		.hash_value(hash_value),
		.least_start(least_start),
		.string_length_out(string_length_out),
		.overflow_flag(overflow_flag)
	);

	always #1 clk = ~clk;

	// least cyclic rotation by two candidates and a match run, then hash from there
	function automatic digest_t digest_of_string();
		int n, a, b, k, ia, ib, pos, first;
		logic [7:0] ca, cb;
		logic [31:0] h;
		digest_t d;
		n = str_len;
		a = 0;
		b = 1;
		k = 0;
		while (a < n && b < n && k < n) begin
			ia = a + k;
			if (ia >= n) ia = ia - n;
			ib = b + k;
			if (ib >= n) ib = ib - n;
			ca = str_mem[ia];
			cb = str_mem[ib];
			if (ca == cb) begin
				k++;
			end else if (ca > cb) begin
				a = a + k + 1;
				if (a <= b) a = b + 1;
				k = 0;
			end else begin
				b = b + k + 1;
				if (b <= a) b = a + 1;
				k = 0;
			end
		end
		first = (n == 0) ? 0 : ((a < b) ? a : b);
		h = rish_pkg::HASH_SEED;
		pos = first;
		for (int c = 0; c < n; c++) begin
			h = ((h << rish_pkg::HASH_SHIFT) + h) ^ {24'd0, str_mem[pos]};
			pos++;
			if (pos >= n) pos = 0;
		end
		d.hash = h;
		d.first = first[7:0];
		d.len = n[8:0];
		d.ovf = str_dropped;
		return d;
	endfunction

	task automatic absorb_request(input logic [7:0] b, input logic l, input logic e);
		if (!e) begin
			if (str_len < CAP) begin
				str_mem[str_len] = b;
				str_len++;
			end else begin
				str_dropped = 1'b1;
			end
		end
		if (e || l) begin
			pending_digests.push_back(digest_of_string());
			str_len = 0;
			str_dropped = 1'b0;
		end
	endtask

	task automatic send_request(input logic [7:0] b, input logic l, input logic e);
		while ($urandom_range(99) < gap_pct) begin
			@(negedge clk);
			start <= 1'b0;
			data_byte <= 8'($urandom);
		end
		@(negedge clk);
		start <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		empty_string <= e;
		@(posedge clk);
		while (busy) @(posedge clk);
		absorb_request(b, l, e);
	endtask

	task automatic send_string(input logic [7:0] body[$], input string_end_t how);
		int n;
		n = body.size();
		if (n == 0) begin
			send_request(8'($urandom), 1'($urandom), 1'b1);
		end else begin
			for (int i = 0; i < n - 1; i++) send_request(body[i], 1'b0, 1'b0);
			if (how == END_ON_LAST) begin
				send_request(body[n - 1], 1'b1, 1'b0);
			end else begin
				send_request(body[n - 1], 1'b0, 1'b0);
				send_request(8'($urandom), 1'($urandom), 1'b1);
			end
		end
	endtask

	// random bytes, a two-symbol alphabet, or a repeated motif so rotations tie often
	function automatic void fill_string(ref logic [7:0] body[$], input int len);
		int flavor, mlen;
		logic [7:0] sym0, sym1;
		logic [7:0] motif [4];
		body.delete();
		flavor = $urandom_range(2);
		sym0 = 8'($urandom);
		sym1 = 8'($urandom);
		if ($urandom_range(3) == 0) begin
			sym0 = 8'h00;
			sym1 = 8'hFF;
		end
		mlen = $urandom_range(1, 4);
		for (int m = 0; m < 4; m++) motif[m] = $urandom_range(1) ? sym0 : sym1;
		for (int i = 0; i < len; i++) begin
			case (flavor)
				0: body.push_back(8'($urandom));
				1: body.push_back($urandom_range(1) ? sym0 : sym1);
				default: body.push_back(motif[i % mlen]);
			endcase
		end
	endfunction

	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (pending_digests.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		gap_pct = 0;
		send_request(8'h00, 1'b0, 1'b1);
		// both marks: data ignored, empty string
		send_request(8'hFF, 1'b1, 1'b1);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'h42, 1'b0, 1'b0);
		send_request(8'h41, 1'b1, 1'b0);
		// all bytes equal, match run reaches the length
		repeat (3) send_request(8'h61, 1'b0, 1'b0);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b0, 1'b0);
		send_request(8'h61, 1'b0, 1'b0);
		send_request(8'h62, 1'b0, 1'b0);
		send_request(8'h61, 1'b1, 1'b0);
		// empty mark after bytes closes the string without adding one
		send_request(8'h7F, 1'b0, 1'b0);
		send_request(8'h80, 1'b0, 1'b0);
		send_request(8'h55, 1'b1, 1'b1);
		send_request(8'hFF, 1'b0, 1'b0);
		send_request(8'h01, 1'b0, 1'b0);
		send_request(8'hFF, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b0);
		settle();
	endtask

	task automatic test_random(input int strings, input int pct);
		int r, len;
		logic [7:0] body[$];
		gap_pct = pct;
		repeat (strings) begin
			r = $urandom_range(99);
			if (r < 5) len = 0;
			else if (r < 85) len = $urandom_range(1, 8);
			else len = $urandom_range(9, 40);
			fill_string(body, len);
			send_string(body, ($urandom_range(99) < 75) ? END_ON_LAST : END_ON_MARK);
		end
		settle();
	endtask

	// full store, then a dropped middle byte and a dropped final byte
	task automatic test_overflow();
		logic [7:0] body[$];
		gap_pct = 16;
		fill_string(body, CAP + 2);
		send_string(body, END_ON_LAST);
		settle();
	endtask

	always @(posedge clk) begin
		digest_t want, got;
		if (arst_n && done === 1'b1) begin
			got = {hash_value, least_start, string_length_out, overflow_flag};
			if (pending_digests.size() == 0) begin
				if (miss_count < 10)
					$display("unexpected result: hash %h start %0d len %0d ovf %b",
						got.hash, got.first, got.len, got.ovf);
				miss_count++;
			end else begin
				want = pending_digests.pop_front();
				if (got !== want) begin
					if (miss_count < 10)
						$display("mismatch: expected hash %h start %0d len %0d ovf %b,",
							want.hash, want.first, want.len, want.ovf,
							" got hash %h start %0d len %0d ovf %b",
							got.hash, got.first, got.len, got.ovf);
					miss_count++;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		data_byte = 8'h00;
		last_byte = 1'b0;
		empty_string = 1'b0;
		gap_pct = 0;
		str_len = 0;
		str_dropped = 1'b0;
		miss_count = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(13, 0);
		test_overflow();
		test_random(13, 57);
		test_random(13, 16);
		if (miss_count == 0)
			$display("PASS rotation_invariant_string_hash");
		else
			$display("FAIL rotation_invariant_string_hash");
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL rotation_invariant_string_hash");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/rish_pkg.sv
hdl/rish_ram.sv
hdl/rish_ctrl.sv
hdl/rish_dp.sv
hdl/rotation_invariant_string_hash.sv
sim/rotation_invariant_string_hash_tb.sv
